// ----- design/lsbbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsbbp_pkg
// Shared types and constants of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lsbbp_pkg;

  localparam int WORD_W    = 32;
  localparam int LEN_W     = 6;
  localparam int BYTES_W   = 3;
  localparam int ACC_W     = 2 * WORD_W;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 40;
  localparam int RES_FIFO_DEPTH = 4;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  // One result item.
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [BYTES_W-1:0] bytes;
    logic               last;
  } res_t;

  // Results produced by one input item, in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       e0;
    res_t       e1;
  } push_t;

endpackage

// ----- design/lsbbp_core.sv -----
// ----------------------------------------------------------------------------
// lsbbp_core
// Bit accumulator and pending count; works out the results of one item.
// ----------------------------------------------------------------------------
module lsbbp_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  lsbbp_pkg::op_t             op,
  input  logic [lsbbp_pkg::WORD_W-1:0] code_bits,
  input  logic [lsbbp_pkg::LEN_W-1:0]  code_length,
  output lsbbp_pkg::push_t           push
);
  import lsbbp_pkg::*;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [LEN_W-1:0]   pend_r, pend_nxt;
  logic               full;
  logic [ACC_W-1:0]   acc_d;
  logic [LEN_W-1:0]   pend_d;
  logic [LEN_W-1:0]   len_s;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  code_m;
  logic [LEN_W-1:0]   byte_sum;
  res_t               res_full, res_last;

  // A full word is pending exactly when bit 5 of the count is set.
  assign full   = pend_r[LEN_W-1];
  assign acc_d  = full ? {{WORD_W{1'b0}}, acc_r[ACC_W-1:WORD_W]} : acc_r;
  assign pend_d = {1'b0, pend_r[LEN_W-2:0]};

  // Lengths above one word saturate to a whole word.
  assign len_s = (code_length[LEN_W-1] && (|code_length[LEN_W-2:0])) ?
                 LEN_W'(WORD_W) : code_length;
  assign mask  = len_s[LEN_W-1] ? {WORD_W{1'b1}} :
                 ((WORD_W'(1) << len_s[LEN_W-2:0]) - WORD_W'(1));
  assign code_m = code_bits & mask;

  assign byte_sum = pend_d + LEN_W'(7);

  always_comb begin
    res_full.word  = acc_r[WORD_W-1:0];
    res_full.bytes = BYTES_W'(4);
    res_full.last  = 1'b0;
    res_last.word  = acc_d[WORD_W-1:0];
    res_last.bytes = byte_sum[LEN_W-1:3];
    res_last.last  = 1'b1;

    push.cnt = {1'b0, full} + {1'b0, (op == OP_FLUSH)};
    push.e0  = full ? res_full : res_last;
    push.e1  = res_last;

    case (op)
      OP_APPEND: begin
        acc_nxt  = acc_d | ({{WORD_W{1'b0}}, code_m} << pend_d[LEN_W-2:0]);
        pend_nxt = pend_d + len_s;
      end
      OP_FLUSH: begin
        acc_nxt  = '0;
        pend_nxt = '0;
      end
      default: begin
        acc_nxt  = acc_r;
        pend_nxt = pend_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
    end else if (step) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// ----- design/lsbbp_fifo.sv -----
// ----------------------------------------------------------------------------
// lsbbp_fifo
// Small result queue that takes up to two items per cycle and gives one.
// ----------------------------------------------------------------------------
module lsbbp_fifo #(
  parameter int DEPTH = lsbbp_pkg::RES_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_en,
  input  lsbbp_pkg::push_t push,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output lsbbp_pkg::res_t  out_res
);
  import lsbbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       n_push;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign n_push    = push_en ? push.cnt : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= CNT_W'(DEPTH - 2));
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (n_push)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push.e0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/lsb_first_bit_packer_unit.sv -----
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_unit
// Packs variable-length codes LSB first into 32-bit words.
// ----------------------------------------------------------------------------
// The input stream carries one code per item: tuser selects append or flush,
// tdata holds the code and its length (0 to 32; longer lengths count as 32).
// Appended bits sit just above those already pending. The result stream
// gives 32-bit words with a count of valid bytes; tlast marks the final,
// possibly partial, word of a flush, after which the packer starts afresh.
// An input item is registered on acceptance and processed once the result
// queue has two free entries; its results then enter the four-entry result
// queue. One item is accepted per cycle while the queue keeps that room; a
// flush that also drains a full word yields two results, and the rate is then
// set by the single result port, one word per cycle while out_tready is high.
// While the receiver stalls, the queue fills and in_tready falls once fewer
// than two entries are free. Reset empties the queue and clears the
// accumulator and pending count.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_unit #(
  parameter int RES_DEPTH = lsbbp_pkg::RES_FIFO_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lsbbp_pkg::IN_DATA_W-1:0]  in_tdata,  // code_bits, code_length
  input  logic                             in_tuser,  // op
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lsbbp_pkg::OUT_DATA_W-1:0] out_tdata, // out_word, valid_bytes
  output logic                             out_tlast
);
  import lsbbp_pkg::*;

  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [WORD_W-1:0] s1_code_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic              s1_adv;
  logic              in_acc;
  logic              room2;
  push_t             push;
  res_t              out_res;

  assign s1_adv    = s1_valid_r && room2;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_t'(in_tuser);
      s1_code_r <= in_tdata[WORD_W-1:0];
      s1_len_r  <= in_tdata[WORD_W+LEN_W-1:WORD_W];
    end
  end

  lsbbp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .op          (s1_op_r),
    .code_bits   (s1_code_r),
    .code_length (s1_len_r),
    .push        (push)
  );

  lsbbp_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (s1_adv),
    .push      (push),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {(OUT_DATA_W - WORD_W - BYTES_W)'(0), out_res.bytes, out_res.word};
  assign out_tlast = out_res.last;

endmodule
